// ===== rtl/fmop_pkg.sv =====
// Shared types, constants and the sine table builder for the FM operator matrix.
`timescale 1ns / 1ps
package fmop_pkg;

    localparam int OP_SLOTS      = 6;
    localparam int OPERATORS_DEF = 6;
    localparam int SINE_BITS_DEF = 10;
    localparam int PHASE_W       = 24;
    localparam int SAMPLE_W      = 16;
    localparam int FIELD_W       = 10;
    localparam int FUND_W        = 16;
    localparam int BASE_W        = 24;
    localparam int ROUTE_W       = 36;
    localparam int CFG_W         = 64;
    localparam int ADDR_W        = 6;
    localparam int QUO_W         = 34;

    localparam logic [2:0] REG_BASE_STEP   = 3'd0;
    localparam logic [2:0] REG_FUNDAMENTAL = 3'd1;
    localparam logic [2:0] REG_RATIO       = 3'd2;
    localparam logic [2:0] REG_MOD_INDEX   = 3'd3;
    localparam logic [2:0] REG_LEVEL       = 3'd4;
    localparam logic [2:0] REG_ROUTING     = 3'd5;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_NUM,
        ST_DIV,
        ST_PHASE,
        ST_SINE,
        ST_LEVEL,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath, one strobe per step.
    typedef struct packed {
        logic start;
        logic mul1;
        logic mul2;
        logic num;
        logic div_step;
        logic phase;
        logic sine;
        logic level;
        logic commit;
    } t_dp_cmd;

    // One sine table entry: Taylor series on the folded quarter wave, Q15 result.
    function automatic logic signed [15:0] sine_entry(input int bits, input int k);
        logic [63:0] quarter;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        quarter = 64'd1 << (bits - 2);
        quad    = (64'(k) >> (bits - 2)) & 64'd3;
        r       = 64'(k) & (quarter - 64'd1);
        if (quad[0]) begin
            r = quarter - r;
        end
        x    = (PI_HALF_Q30 * r) >> (bits - 2);
        x2   = (x * x) >> 30;
        sum  = x;
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        mag  = (sum + 64'd16384) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        sine_entry = quad[1] ? -$signed(16'(mag)) : $signed(16'(mag));
    endfunction

endpackage

// ===== rtl/fmop_ctrl.sv =====
// Controller state machine that sequences the operators through the datapath.
`timescale 1ns / 1ps
module fmop_ctrl
    import fmop_pkg::*;
#(
    parameter int OPERATORS = OPERATORS_DEF,
    parameter int OP_W      = $clog2(OPERATORS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_dp_cmd         o_cmd,
    output logic [OP_W-1:0] o_op
);

    localparam int CNT_W = $clog2(QUO_W);

    t_state           r_state;
    t_state           n_state;
    logic [OP_W-1:0]  r_op;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             w_last_op;
    logic             w_div_end;
    logic             w_out_free;

    assign w_last_op  = (r_op == OP_W'(OPERATORS - 1));
    assign w_div_end  = (r_cnt == CNT_W'(QUO_W - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_NUM;
            ST_NUM:   n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_end) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: n_state = ST_SINE;
            ST_SINE:  n_state = ST_LEVEL;
            ST_LEVEL: n_state = w_last_op ? ST_DONE : ST_MUL1;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Command strobes.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.start    = i_in_valid;
            ST_MUL1:  o_cmd.mul1     = 1'b1;
            ST_MUL2:  o_cmd.mul2     = 1'b1;
            ST_NUM:   o_cmd.num      = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_PHASE: o_cmd.phase    = 1'b1;
            ST_SINE:  o_cmd.sine     = 1'b1;
            ST_LEVEL: o_cmd.level    = 1'b1;
            ST_DONE:  o_cmd.commit   = w_out_free;
            default:  o_cmd          = '0;
        endcase
    end

    // State, operator and divider counters, result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_cnt <= w_div_end ? '0 : r_cnt + CNT_W'(1);
            end
            if (r_state == ST_LEVEL) begin
                r_op <= w_last_op ? '0 : r_op + OP_W'(1);
            end
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_op        = r_op;

endmodule

// ===== rtl/fmop_dp.sv =====
// Datapath: modulation sum, multipliers, serial divider, phase store, sine ROM and level.
`timescale 1ns / 1ps
module fmop_dp
    import fmop_pkg::*;
#(
    parameter int OPERATORS       = OPERATORS_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF,
    parameter int OP_W            = $clog2(OPERATORS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic [OP_W-1:0]            i_op,
    input  logic                       i_restart,
    input  logic [BASE_W-1:0]          i_base_step,
    input  logic [FUND_W-1:0]          i_fundamental,
    input  logic [FIELD_W*OP_SLOTS-1:0] i_ratio,
    input  logic [FIELD_W*OP_SLOTS-1:0] i_index,
    input  logic [FIELD_W*OP_SLOTS-1:0] i_level,
    input  logic [ROUTE_W-1:0]         i_routing,
    output logic signed [SAMPLE_W-1:0] o_sample [OP_SLOTS]
);

    localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;

    logic [PHASE_W-1:0]         r_phase [OPERATORS];
    logic signed [SAMPLE_W-1:0] r_prev  [OPERATORS];
    logic signed [SAMPLE_W-1:0] r_next  [OPERATORS];
    logic signed [SAMPLE_W-1:0] r_out   [OP_SLOTS];
    logic [33:0]                r_a;
    logic signed [28:0]         r_m;
    logic signed [53:0]         r_p;
    logic [21:0]                r_l;
    logic                       r_neg;
    logic [QUO_W-1:0]           r_dq;
    logic [FUND_W-1:0]          r_rem;
    logic signed [SAMPLE_W-1:0] r_sine;

    logic signed [SAMPLE_W-1:0] w_rom [SINE_DEPTH];
    logic [FUND_W-1:0]          w_fund;
    logic [FIELD_W-1:0]         w_ratio;
    logic [FIELD_W-1:0]         w_idx;
    logic [FIELD_W-1:0]         w_lvl;
    logic signed [18:0]         w_sum;
    logic signed [29:0]         w_mprod;
    logic signed [53:0]         w_pprod;
    logic signed [54:0]         w_num;
    logic signed [QUO_W-1:0]    w_n;
    logic [FUND_W:0]            w_t;
    logic                       w_ge;
    logic [PHASE_W-1:0]         w_q24;
    logic [PHASE_W-1:0]         w_delta;
    logic signed [26:0]         w_lprod;

    // Constant sine table, one entry per phase code.
    for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_rom
        assign w_rom[k] = sine_entry(SINE_TABLE_BITS, k);
    end

    assign w_fund  = (i_fundamental == '0) ? FUND_W'(1) : i_fundamental;
    assign w_ratio = i_ratio[int'(i_op)*FIELD_W +: FIELD_W];
    assign w_idx   = i_index[int'(i_op)*FIELD_W +: FIELD_W];
    assign w_lvl   = i_level[int'(i_op)*FIELD_W +: FIELD_W];

    // Sum of the previous samples routed into the current operator.
    always_comb begin
        w_sum = '0;
        for (int s = 0; s < OPERATORS; s++) begin
            if (i_routing[s*OP_SLOTS + int'(i_op)]) begin
                w_sum = w_sum + 19'(r_prev[s]);
            end
        end
    end

    assign w_mprod = 30'(w_sum) * $signed({20'b0, w_idx});
    assign w_pprod = $signed({30'b0, i_base_step}) * 54'(r_m);
    assign w_num   = 55'(r_p) + $signed({18'b0, r_l, 15'b0});
    assign w_n     = w_num[54:21];

    // One restoring division step per cycle.
    assign w_t  = {r_rem, r_dq[QUO_W-1]};
    assign w_ge = (w_t >= {1'b0, w_fund});

    // Floor quotient reduced to phase width, then the phase increment.
    assign w_q24   = r_neg ? -(r_dq[PHASE_W-1:0] + PHASE_W'(r_rem != '0))
                           : r_dq[PHASE_W-1:0];
    assign w_delta = r_a[29:6] + w_q24;

    assign w_lprod = 27'(r_sine) * $signed({17'b0, w_lvl});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < OPERATORS; i++) begin
                r_phase[i] <= '0;
                r_prev[i]  <= '0;
            end
            for (int i = 0; i < OP_SLOTS; i++) begin
                r_out[i] <= '0;
            end
        end else begin
            if (i_cmd.start && i_restart) begin
                for (int i = 0; i < OPERATORS; i++) begin
                    r_phase[i] <= '0;
                    r_prev[i]  <= '0;
                end
            end
            if (i_cmd.mul1) begin
                r_a <= 34'(i_base_step) * 34'(w_ratio);
                r_m <= w_mprod[28:0];
            end
            if (i_cmd.mul2) begin
                r_p <= w_pprod;
                r_l <= 22'(r_a[5:0]) * 22'(w_fund);
            end
            if (i_cmd.num) begin
                r_neg <= w_n[QUO_W-1];
                r_dq  <= w_n[QUO_W-1] ? QUO_W'(-w_n) : QUO_W'(w_n);
                r_rem <= '0;
            end
            if (i_cmd.div_step) begin
                r_rem <= w_ge ? FUND_W'(w_t - {1'b0, w_fund}) : w_t[FUND_W-1:0];
                r_dq  <= {r_dq[QUO_W-2:0], w_ge};
            end
            if (i_cmd.phase) begin
                r_phase[i_op] <= r_phase[i_op] + w_delta;
            end
            if (i_cmd.sine) begin
                r_sine <= w_rom[r_phase[i_op][PHASE_W-1 -: SINE_TABLE_BITS]];
            end
            if (i_cmd.level) begin
                r_next[i_op] <= w_lprod[25:10];
            end
            // All operators read last tick's samples; commit them together.
            if (i_cmd.commit) begin
                for (int i = 0; i < OPERATORS; i++) begin
                    r_prev[i] <= r_next[i];
                end
                for (int i = 0; i < OP_SLOTS; i++) begin
                    r_out[i] <= (i < OPERATORS) ? r_next[i % OPERATORS] : '0;
                end
            end
        end
    end

    assign o_sample = r_out;

endmodule

// ===== rtl/fm_operator_matrix_step.sv =====
// Top level of the FM operator matrix: register file, controller and datapath.
//
//  channel  direction  handshake                   payload
//  input    in         i_in_valid / o_in_stall     i_restart
//  output   out        o_out_valid / i_out_stall   o_op_sample_0 .. o_op_sample_5
//  config   in         psel penable pwrite pready  paddr pwdata / prdata
//
// Each tick runs every operator in turn through the one-bit-per-cycle divider,
// 34 steps per operator.
// Reset is synchronous and clears phases, previous samples and control.
// A finished result waits in the output register while the next tick is taken and
// computed; that tick then holds in its last state until the output is free.
`timescale 1ns / 1ps
module fm_operator_matrix_step
    import fmop_pkg::*;
#(
    parameter int OPERATORS       = OPERATORS_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [CFG_W-1:0]           pwdata,
    output logic [CFG_W-1:0]           prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_restart,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_op_sample_0,
    output logic signed [SAMPLE_W-1:0] o_op_sample_1,
    output logic signed [SAMPLE_W-1:0] o_op_sample_2,
    output logic signed [SAMPLE_W-1:0] o_op_sample_3,
    output logic signed [SAMPLE_W-1:0] o_op_sample_4,
    output logic signed [SAMPLE_W-1:0] o_op_sample_5
);

    localparam int OP_W = $clog2(OPERATORS);

    logic [BASE_W-1:0]           r_base_step;
    logic [FUND_W-1:0]           r_fundamental;
    logic [FIELD_W*OP_SLOTS-1:0] r_ratio;
    logic [FIELD_W*OP_SLOTS-1:0] r_index;
    logic [FIELD_W*OP_SLOTS-1:0] r_level;
    logic [ROUTE_W-1:0]          r_routing;

    logic [2:0]                  w_reg;
    logic                        w_wr;
    t_dp_cmd                     w_cmd;
    logic [OP_W-1:0]             w_op;
    logic signed [SAMPLE_W-1:0]  w_sample [OP_SLOTS];

    assign pready = 1'b1;
    assign w_reg  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes on the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step   <= '0;
            r_fundamental <= FUND_W'(440);
            r_ratio       <= '0;
            r_index       <= '0;
            r_level       <= '0;
            r_routing     <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_BASE_STEP:   r_base_step   <= pwdata[BASE_W-1:0];
                REG_FUNDAMENTAL: r_fundamental <= pwdata[FUND_W-1:0];
                REG_RATIO:       r_ratio       <= pwdata[FIELD_W*OP_SLOTS-1:0];
                REG_MOD_INDEX:   r_index       <= pwdata[FIELD_W*OP_SLOTS-1:0];
                REG_LEVEL:       r_level       <= pwdata[FIELD_W*OP_SLOTS-1:0];
                REG_ROUTING:     r_routing     <= pwdata[ROUTE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_reg)
            REG_BASE_STEP:   prdata = CFG_W'(r_base_step);
            REG_FUNDAMENTAL: prdata = CFG_W'(r_fundamental);
            REG_RATIO:       prdata = CFG_W'(r_ratio);
            REG_MOD_INDEX:   prdata = CFG_W'(r_index);
            REG_LEVEL:       prdata = CFG_W'(r_level);
            REG_ROUTING:     prdata = CFG_W'(r_routing);
            default:         prdata = '0;
        endcase
    end

    fmop_ctrl #(
        .OPERATORS (OPERATORS),
        .OP_W      (OP_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .o_op        (w_op)
    );

    fmop_dp #(
        .OPERATORS       (OPERATORS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .OP_W            (OP_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_op          (w_op),
        .i_restart     (i_restart),
        .i_base_step   (r_base_step),
        .i_fundamental (r_fundamental),
        .i_ratio       (r_ratio),
        .i_index       (r_index),
        .i_level       (r_level),
        .i_routing     (r_routing),
        .o_sample      (w_sample)
    );

    assign o_op_sample_0 = w_sample[0];
    assign o_op_sample_1 = w_sample[1];
    assign o_op_sample_2 = w_sample[2];
    assign o_op_sample_3 = w_sample[3];
    assign o_op_sample_4 = w_sample[4];
    assign o_op_sample_5 = w_sample[5];

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the six-operator FM matrix step block.
`timescale 1ns / 1ps
module tb_top;
    import fmop_pkg::*;

    typedef logic [OP_SLOTS-1:0][SAMPLE_W-1:0] t_samples;

    // One row of the directed table: setting to apply, restart bit and
    // whether the result is known to be silence.
    typedef struct {
        int cfg_set;
        bit restart;
        bit silent;
    } t_row;

    localparam int RANDOM_TICKS = 1200;
    localparam int RANDOM_PHASES = 12;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int HOLD_CYCLES = 1500;

    // Register index past the end of the map.
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [CFG_W-1:0]           pwdata;
    logic [CFG_W-1:0]           prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_restart;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_op_sample_0;
    logic signed [SAMPLE_W-1:0] o_op_sample_1;
    logic signed [SAMPLE_W-1:0] o_op_sample_2;
    logic signed [SAMPLE_W-1:0] o_op_sample_3;
    logic signed [SAMPLE_W-1:0] o_op_sample_4;
    logic signed [SAMPLE_W-1:0] o_op_sample_5;

    fm_operator_matrix_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_op_sample_0 (o_op_sample_0),
        .o_op_sample_1 (o_op_sample_1),
        .o_op_sample_2 (o_op_sample_2),
        .o_op_sample_3 (o_op_sample_3),
        .o_op_sample_4 (o_op_sample_4),
        .o_op_sample_5 (o_op_sample_5)
    );

    // Shadow registers and operator state of the predictor.
    logic [BASE_W-1:0]     sh_base_step;
    logic [FUND_W-1:0]     sh_fundamental;
    logic [59:0]           sh_ratio;
    logic [59:0]           sh_mod_index;
    logic [59:0]           sh_level;
    logic [ROUTE_W-1:0]    sh_routing;
    logic [PHASE_W-1:0]    phase_st [OP_SLOTS];
    longint                prev_st [OP_SLOTS];
    longint                sine_lut [1024];

    t_samples              expected_ticks [$];
    int                    mismatches;
    int                    ticks_sent;
    int                    ticks_checked;
    int                    idle_cycles;
    int                    tx_idle_pct;
    int                    rx_stall_pct;
    bit                    hold_req;
    bit                    hold_done;
    int                    hold_cnt;
    bit                    cur_silent;
    t_row                  rows [$];

    // Quarter-wave Taylor series, rounded to Q15 and folded to a full wave.
    function automatic longint sine_value(int k);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned mag;
        quad = (k >> 8) & 3;
        r = k & 255;
        if (quad[0]) begin
            r = 256 - r;
        end
        x = (64'd1686629713 * r) / 256;
        x2 = (x * x) >> 30;
        sum = x;
        term = ((x * x2) >> 30) / 6;
        sum = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum = sum + term;
        mag = (sum + 16384) >> 15;
        if (mag > 32767) begin
            mag = 32767;
        end
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Advances the operator network by one tick and returns its samples.
    function automatic t_samples next_ticks(bit restart);
        t_samples res;
        longint fund;
        longint idxv;
        longint mod_sum;
        longint a;
        longint num;
        longint delta;
        longint s;
        longint p;
        longint nxt [OP_SLOTS];
        fund = (sh_fundamental == 0) ? 1 : longint'(sh_fundamental);
        if (restart) begin
            for (int k = 0; k < OP_SLOTS; k++) begin
                phase_st[k] = '0;
                prev_st[k] = 0;
            end
        end
        for (int op = 0; op < OP_SLOTS; op++) begin
            idxv = longint'(sh_mod_index[10*op +: 10]);
            a = longint'(sh_base_step) * longint'(sh_ratio[10*op +: 10]);
            mod_sum = 0;
            for (int src = 0; src < OP_SLOTS; src++) begin
                if (sh_routing[src*6 + op]) begin
                    mod_sum += prev_st[src] * idxv;
                end
            end
            num = (a & 63) * fund * 32768 + longint'(sh_base_step) * mod_sum;
            delta = (a >>> 6) + floor_quot(num, fund * 2097152);
            phase_st[op] = PHASE_W'(longint'(phase_st[op]) + delta);
            s = sine_lut[phase_st[op][23:14]];
            p = floor_quot(s * longint'(sh_level[10*op +: 10]), 1024);
            if (p > 32767) begin
                p = 32767;
            end
            if (p < -32768) begin
                p = -32768;
            end
            nxt[op] = p;
        end
        for (int op = 0; op < OP_SLOTS; op++) begin
            prev_st[op] = nxt[op];
            res[op] = SAMPLE_W'(nxt[op]);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input transfers feed the predictor; output transfers are checked.
    always @(posedge i_clk) begin
        t_samples got;
        t_samples exp_s;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            exp_s = next_ticks(i_restart);
            expected_ticks.push_back(cur_silent ? t_samples'(0) : exp_s);
            ticks_sent++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_op_sample_5, o_op_sample_4, o_op_sample_3,
                   o_op_sample_2, o_op_sample_1, o_op_sample_0};
            if (expected_ticks.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                exp_s = expected_ticks.pop_front();
                for (int op = 0; op < OP_SLOTS; op++) begin
                    if (got[op] !== exp_s[op]) begin
                        report_mismatch($sformatf("op_sample_%0d got %0d expected %0d",
                            op, $signed(got[op]), $signed(exp_s[op])));
                    end
                end
                ticks_checked++;
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     expected_ticks.size());
            $display("fm_operator_matrix_step regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(idx * 8);
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_BASE_STEP:   sh_base_step = value[BASE_W-1:0];
            REG_FUNDAMENTAL: sh_fundamental = value[FUND_W-1:0];
            REG_RATIO:       sh_ratio = value[59:0];
            REG_MOD_INDEX:   sh_mod_index = value[59:0];
            REG_LEVEL:       sh_level = value[59:0];
            REG_ROUTING:     sh_routing = value[ROUTE_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every result has come back and the block has gone quiet.
    task automatic drain;
        while (expected_ticks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Writes one register setting; negative sets are random.
    task automatic apply_setting(input int set_id);
        logic [15:0] fund;
        fund = 16'($urandom);
        case (set_id)
            0: begin
                write_reg(REG_BASE_STEP, 64'd0);
                write_reg(REG_FUNDAMENTAL, 64'd440);
                write_reg(REG_RATIO, 64'd0);
                write_reg(REG_MOD_INDEX, 64'd0);
                write_reg(REG_LEVEL, 64'd0);
                write_reg(REG_ROUTING, 64'd0);
            end
            1: begin
                write_reg(REG_BASE_STEP, 64'hFF_FFFF);
                write_reg(REG_FUNDAMENTAL, 64'hFFFF);
                write_reg(REG_RATIO, {64{1'b1}});
                write_reg(REG_MOD_INDEX, {64{1'b1}});
                write_reg(REG_LEVEL, {64{1'b1}});
                write_reg(REG_ROUTING, {64{1'b1}});
                // An address past the last register must change nothing.
                write_reg(REG_UNUSED, rand64());
            end
            2: begin
                write_reg(REG_FUNDAMENTAL, 64'd0);
                write_reg(REG_BASE_STEP, 64'h12_3456);
                write_reg(REG_RATIO, rand64());
                write_reg(REG_MOD_INDEX, rand64());
                write_reg(REG_LEVEL, {64{1'b1}});
                write_reg(REG_ROUTING, rand64());
            end
            3: begin
                write_reg(REG_FUNDAMENTAL, 64'd1);
                write_reg(REG_BASE_STEP, 64'hFF_FFFF);
                write_reg(REG_RATIO, 64'h0);
                write_reg(REG_MOD_INDEX, {64{1'b1}});
                write_reg(REG_LEVEL, rand64());
                write_reg(REG_ROUTING, rand64());
            end
            default: begin
                if ($urandom_range(9) == 0) begin
                    fund = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
                end
                write_reg(REG_BASE_STEP, 64'($urandom));
                write_reg(REG_FUNDAMENTAL, 64'(fund));
                write_reg(REG_RATIO, rand64());
                write_reg(REG_MOD_INDEX, rand64());
                write_reg(REG_LEVEL, rand64());
                write_reg(REG_ROUTING, rand64());
            end
        endcase
    endtask

    // Offers one tick and holds it until the block takes it.
    task automatic send_tick(input bit restart, input bit silent);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_restart = restart;
        cur_silent = silent;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Main sequence.
    initial begin
        int last_set;
        int mode;
        mismatches = 0;
        ticks_sent = 0;
        ticks_checked = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        cur_silent = 1'b0;
        tx_idle_pct = 8;
        rx_stall_pct = 84;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_restart = 1'b0;
        i_out_stall = 1'b0;
        i_rst_n = 1'b0;
        sh_base_step = '0;
        sh_fundamental = 16'd440;
        sh_ratio = '0;
        sh_mod_index = '0;
        sh_level = '0;
        sh_routing = '0;
        for (int k = 0; k < OP_SLOTS; k++) begin
            phase_st[k] = '0;
            prev_st[k] = 0;
        end
        for (int k = 0; k < 1024; k++) begin
            sine_lut[k] = sine_value(k);
        end

        // Directed table: reset defaults give silence, then the extremes,
        // a zero fundamental and a one-hertz fundamental at full step.
        rows = '{
            '{0, 0, 1}, '{0, 1, 1}, '{0, 0, 1}, '{0, 0, 1},
            '{1, 0, 0}, '{1, 0, 0}, '{1, 0, 0}, '{1, 1, 0}, '{1, 0, 0}, '{1, 0, 0},
            '{2, 0, 0}, '{2, 0, 0}, '{2, 1, 0}, '{2, 0, 0}, '{2, 0, 0},
            '{3, 0, 0}, '{3, 0, 0}, '{3, 0, 0}, '{3, 1, 0}, '{3, 0, 0}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Ticks straight after reset, before any register write.
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        i_in_valid = 1'b0;

        last_set = -1;
        foreach (rows[r]) begin
            if (rows[r].cfg_set != last_set) begin
                i_in_valid = 1'b0;
                drain();
                apply_setting(rows[r].cfg_set);
                last_set = rows[r].cfg_set;
            end
            send_tick(rows[r].restart, rows[r].silent);
        end
        i_in_valid = 1'b0;

        // Random phases, each with its own setting; the idling pattern changes every four phases.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = ph / 4;
            tx_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 84 : 0;
            rx_stall_pct = (mode == 0) ? 84 : (mode == 1) ? 8 : 0;
            drain();
            apply_setting(-1);
            for (int n = 0; n < RANDOM_TICKS / RANDOM_PHASES; n++) begin
                if (ph == RANDOM_PHASES - 1 && n == 10) begin
                    hold_req = 1'b1;
                end
                send_tick($urandom_range(19) == 0, 1'b0);
            end
            i_in_valid = 1'b0;
        end

        drain();
        $display("Checked %0d of %0d ticks over %0d random register settings,",
                 ticks_checked, ticks_sent, RANDOM_PHASES);
        $display("with directed extremes, restarts, idling and one long output hold-off.");
        if (mismatches == 0 && expected_ticks.size() == 0) begin
            $display("fm_operator_matrix_step regression: pass");
        end else begin
            $display("fm_operator_matrix_step regression: fail");
        end
        $finish;
    end

endmodule
